// ===== rtl/spq_pkg.sv =====
package spq_pkg;

  localparam int unsigned CapacityDef     = 8;
  localparam int unsigned PriorityBitsDef = 16;

  localparam int unsigned ValueW     = 32;
  localparam int unsigned InPriW     = 16;
  localparam int unsigned OccupancyW = 4;
  localparam int unsigned StatusW    = 2;

  localparam logic OpInsert = 1'b0;
  localparam logic OpRemove = 1'b1;

  localparam logic [StatusW-1:0] StatusDone  = 2'd0;
  localparam logic [StatusW-1:0] StatusFull  = 2'd1;
  localparam logic [StatusW-1:0] StatusEmpty = 2'd2;

  typedef struct packed {
    logic                     operation;
    logic signed [ValueW-1:0] entry_value;
    logic signed [InPriW-1:0] entry_priority;
  } spq_in_t;

  typedef struct packed {
    logic signed [ValueW-1:0] head_value;
    logic signed [InPriW-1:0] head_priority;
    logic [OccupancyW-1:0]    occupancy;
    logic [StatusW-1:0]       status;
  } spq_out_t;

  typedef struct packed {
    logic insert_en;
    logic remove_en;
  } spq_ctrl_t;

endpackage

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue of CAPACITY entries held in a row of cells, lowest priority at the
// head, equal priorities in arrival order. Every cell compares the incoming priority with its
// own and holds, loads the new entry or takes its neighbour's entry in the same cycle, so one
// operation is taken per clock; its result (head, occupancy, status) is registered and
// offered in the cycle after the transfer. Input is stalled only while a result waits unread.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned CAPACITY      = CapacityDef,
  parameter int unsigned PRIORITY_BITS = PriorityBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  spq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output spq_out_t out_data_o
);

  localparam int unsigned CountW  = $clog2(CAPACITY + 1);
  localparam int unsigned OccW    = (CountW > OccupancyW) ? CountW : OccupancyW;
  localparam int unsigned PriExtW = (PRIORITY_BITS > InPriW) ? PRIORITY_BITS : InPriW;

  logic [ValueW-1:0]               value_arr [CAPACITY];
  logic signed [PRIORITY_BITS-1:0] pri_arr   [CAPACITY];
  logic [CAPACITY-1:0]             valid_vec;
  logic [CAPACITY-1:0]             keep_vec;

  spq_ctrl_t                       ctrl;
  logic                            accept, is_insert, full, empty;
  logic [PriExtW-1:0]              in_pri_ext, head_pri_ext;
  logic signed [PRIORITY_BITS-1:0] new_pri;
  logic [ValueW-1:0]               head_value;
  logic signed [PRIORITY_BITS-1:0] head_pri;
  logic [CountW-1:0]               count_q, count_d;
  logic [OccW-1:0]                 occ_ext;
  logic                            out_valid_q, out_valid_d;
  spq_out_t                        out_data_q, result;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_insert  = (in_data_i.operation == OpInsert);
  assign full       = valid_vec[CAPACITY-1];
  assign empty      = !valid_vec[0];

  assign ctrl.insert_en = accept && is_insert && !full;
  assign ctrl.remove_en = accept && !is_insert && !empty;

  assign in_pri_ext = PriExtW'($unsigned(in_data_i.entry_priority));
  assign new_pri    = in_pri_ext[PRIORITY_BITS-1:0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ValueW-1:0]               left_value, right_value;
    logic signed [PRIORITY_BITS-1:0] left_pri, right_pri;
    logic                            left_valid, left_keep, right_valid;

    if (i == 0) begin : g_first
      assign left_value = in_data_i.entry_value;
      assign left_pri   = new_pri;
      assign left_valid = 1'b1;
      assign left_keep  = 1'b1;
    end else begin : g_mid_left
      assign left_value = value_arr[i-1];
      assign left_pri   = pri_arr[i-1];
      assign left_valid = valid_vec[i-1];
      assign left_keep  = keep_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = '0;
      assign right_pri   = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_right
      assign right_value = value_arr[i+1];
      assign right_pri   = pri_arr[i+1];
      assign right_valid = valid_vec[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_value_i  (in_data_i.entry_value),
      .new_pri_i    (new_pri),
      .left_value_i (left_value),
      .left_pri_i   (left_pri),
      .left_valid_i (left_valid),
      .left_keep_i  (left_keep),
      .right_value_i(right_value),
      .right_pri_i  (right_pri),
      .right_valid_i(right_valid),
      .value_o      (value_arr[i]),
      .pri_o        (pri_arr[i]),
      .valid_o      (valid_vec[i]),
      .keep_o       (keep_vec[i])
    );
  end

  always_comb begin
    head_value = value_arr[0];
    head_pri   = pri_arr[0];
    if (ctrl.insert_en && !keep_vec[0]) begin
      head_value = in_data_i.entry_value;
      head_pri   = new_pri;
    end else if (ctrl.remove_en) begin
      head_value = value_arr[1];
      head_pri   = pri_arr[1];
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.insert_en) begin
      count_d = count_q + CountW'(1);
    end else if (ctrl.remove_en) begin
      count_d = count_q - CountW'(1);
    end
  end

  assign head_pri_ext = PriExtW'($unsigned(head_pri));
  assign occ_ext      = OccW'(count_d);

  always_comb begin
    result.occupancy = occ_ext[OccupancyW-1:0];
    if (count_d != '0) begin
      result.head_value    = head_value;
      result.head_priority = head_pri_ext[InPriW-1:0];
    end else begin
      result.head_value    = '0;
      result.head_priority = '0;
    end
    if (is_insert) begin
      result.status = full ? StatusFull : StatusDone;
    end else begin
      result.status = empty ? StatusEmpty : StatusDone;
    end
  end

  assign out_valid_d = accept || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CountW'($countones(valid_vec)))
    else $error("held count disagrees with occupied cells");

  a_cells_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + CAPACITY'(1))) == '0)
    else $error("occupied cells not a contiguous run from the head");

  a_out_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_data_q.occupancy == OccupancyW'(count_q))
    else $error("reported occupancy differs from held count");

  a_empty_head_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.status == StatusEmpty) |->
      (out_data_q.head_value == '0 && out_data_q.head_priority == '0))
    else $error("empty remove reports a non-zero head");

endmodule

// ===== rtl/spq_cell.sv =====
module spq_cell import spq_pkg::*; #(
  parameter int unsigned PRIORITY_BITS = PriorityBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  spq_ctrl_t                       ctrl_i,
  input  logic [ValueW-1:0]               new_value_i,
  input  logic signed [PRIORITY_BITS-1:0] new_pri_i,
  input  logic [ValueW-1:0]               left_value_i,
  input  logic signed [PRIORITY_BITS-1:0] left_pri_i,
  input  logic                            left_valid_i,
  input  logic                            left_keep_i,
  input  logic [ValueW-1:0]               right_value_i,
  input  logic signed [PRIORITY_BITS-1:0] right_pri_i,
  input  logic                            right_valid_i,
  output logic [ValueW-1:0]               value_o,
  output logic signed [PRIORITY_BITS-1:0] pri_o,
  output logic                            valid_o,
  output logic                            keep_o
);

  logic [ValueW-1:0]               value_q, value_d;
  logic signed [PRIORITY_BITS-1:0] pri_q, pri_d;
  logic                            valid_q, valid_d;
  logic                            keep;

  assign keep = valid_q && (pri_q <= new_pri_i);

  always_comb begin
    value_d = value_q;
    pri_d   = pri_q;
    valid_d = valid_q;
    if (ctrl_i.insert_en) begin
      valid_d = valid_q | left_valid_i;
      if (!keep) begin
        if (left_keep_i) begin
          value_d = new_value_i;
          pri_d   = new_pri_i;
        end else begin
          value_d = left_value_i;
          pri_d   = left_pri_i;
        end
      end
    end else if (ctrl_i.remove_en) begin
      value_d = right_value_i;
      pri_d   = right_pri_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    pri_q   <= pri_d;
  end

  assign value_o = value_q;
  assign pri_o   = pri_q;
  assign valid_o = valid_q;
  assign keep_o  = keep;

endmodule

// ===== tb/sorted_priority_queue_tb.sv =====
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
  import spq_pkg::*;

  class spq_ledger;
    spq_out_t                 expected_q[$];
    logic signed [ValueW-1:0] slot_val[CapacityDef];
    logic signed [InPriW-1:0] slot_pri[CapacityDef];
    int unsigned              held;
    int unsigned              errors;
    int unsigned              checked;
    int unsigned              inserts;
    int unsigned              removes;
    int unsigned              full_drops;
    int unsigned              empty_removes;
    int unsigned              peak_held;

    function void clear();
      expected_q.delete();
      held = 0;
      errors = 0;
      checked = 0;
      inserts = 0;
      removes = 0;
      full_drops = 0;
      empty_removes = 0;
      peak_held = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_transfer(spq_in_t item);
      spq_out_t exp_res;
      int       pos;
      exp_res = '0;
      exp_res.status = StatusDone;
      if (item.operation == OpInsert) begin
        inserts++;
        if (held >= CapacityDef) begin
          exp_res.status = StatusFull;
          full_drops++;
        end else begin
          pos = 0;
          while (pos < held && slot_pri[pos] <= item.entry_priority) pos++;
          for (int i = held; i > pos; i--) begin
            slot_val[i] = slot_val[i-1];
            slot_pri[i] = slot_pri[i-1];
          end
          slot_val[pos] = item.entry_value;
          slot_pri[pos] = item.entry_priority;
          held++;
        end
      end else begin
        removes++;
        if (held == 0) begin
          exp_res.status = StatusEmpty;
          empty_removes++;
        end else begin
          for (int i = 0; i + 1 < held; i++) begin
            slot_val[i] = slot_val[i+1];
            slot_pri[i] = slot_pri[i+1];
          end
          held--;
        end
      end
      if (held > 0) begin
        exp_res.head_value    = slot_val[0];
        exp_res.head_priority = slot_pri[0];
      end
      exp_res.occupancy = OccupancyW'(held);
      if (held > peak_held) peak_held = held;
      expected_q.push_back(exp_res);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(spq_out_t got);
      spq_out_t exp_res;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      exp_res = expected_q.pop_front();
      checked++;
      if (got.head_value !== exp_res.head_value)
        report_mismatch($sformatf("head_value %0d, want %0d",
                                  got.head_value, exp_res.head_value));
      if (got.head_priority !== exp_res.head_priority)
        report_mismatch($sformatf("head_priority %0d, want %0d",
                                  got.head_priority, exp_res.head_priority));
      if (got.occupancy !== exp_res.occupancy)
        report_mismatch($sformatf("occupancy %0d, want %0d",
                                  got.occupancy, exp_res.occupancy));
      if (got.status !== exp_res.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, exp_res.status));
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  spq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  spq_out_t out_data;

  int        send_idle_mode = 0;
  int        recv_idle_mode = 0;
  spq_ledger ledger = new();

  sorted_priority_queue uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned draw_gap(int mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(3) == 0) ? $urandom_range(17) : 0;
      default: return $urandom_range(17);
    endcase
  endfunction

  function automatic spq_in_t make_item(logic op, logic [ValueW-1:0] val,
                                        logic [InPriW-1:0] pri);
    spq_in_t item;
    item.operation      = op;
    item.entry_value    = val;
    item.entry_priority = pri;
    return item;
  endfunction

  function automatic spq_in_t random_item(int unsigned insert_pct, bit narrow);
    logic [InPriW-1:0] pri;
    if (narrow) pri = InPriW'($urandom_range(3)) - InPriW'(2);
    else begin
      case ($urandom_range(19))
        0: pri = {1'b1, {(InPriW-1){1'b0}}};
        1: pri = {1'b0, {(InPriW-1){1'b1}}};
        default: pri = InPriW'($urandom());
      endcase
    end
    return make_item(($urandom_range(99) < insert_pct) ? OpInsert : OpRemove,
                     ValueW'($urandom()), pri);
  endfunction

  task automatic send_item(spq_in_t item);
    int unsigned gap;
    gap = draw_gap(send_idle_mode);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    ledger.note_transfer(item);
  endtask

  task automatic wait_drained(int unsigned limit);
    int unsigned n;
    n = 0;
    while (ledger.pending() != 0 && n < limit) begin
      @(posedge clk);
      n++;
    end
  endtask

  initial begin
    int unsigned gap;
    wait (rst_n);
    forever begin
      gap = draw_gap(recv_idle_mode);
      if (gap > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      ledger.check_result(out_data);
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", ledger.pending());
    $display("sorted_priority_queue_tb failed");
    $finish;
  end

  initial begin
    int unsigned insert_pct;
    bit          narrow;
    ledger.clear();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty remove, extremes, ties, fill, full drop, drain, empty again
    send_item(make_item(OpRemove, '1, '1));
    send_item(make_item(OpInsert, 32'h7FFF_FFFF, 16'h7FFF));
    send_item(make_item(OpInsert, 32'h8000_0000, 16'h8000));
    send_item(make_item(OpInsert, 32'h0000_0000, 16'h0000));
    send_item(make_item(OpInsert, 32'hFFFF_FFFF, 16'h0000));
    send_item(make_item(OpInsert, 32'h0000_0001, 16'hFFFF));
    send_item(make_item(OpInsert, 32'h5555_5555, 16'h5555));
    send_item(make_item(OpInsert, 32'hAAAA_AAAA, 16'hAAAA));
    send_item(make_item(OpInsert, 32'd123, 16'h7FFF));
    send_item(make_item(OpInsert, 32'd99, 16'h8000));
    repeat (CapacityDef) send_item(make_item(OpRemove, '0, '0));
    send_item(make_item(OpRemove, '0, '0));
    send_item(make_item(OpInsert, 32'h1234_5678, 16'h0001));
    send_item(make_item(OpRemove, '1, '1));

    for (int phase = 0; phase < 20; phase++) begin
      case ($urandom_range(2))
        0: insert_pct = 15;
        1: insert_pct = 50;
        default: insert_pct = 85;
      endcase
      narrow = $urandom_range(1);
      send_idle_mode = (phase < 2) ? 0 : $urandom_range(2);
      recv_idle_mode = (phase < 2) ? 0 : $urandom_range(2);
      if (phase == 10) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained(1000);
      end
      repeat (50) send_item(random_item(insert_pct, narrow));
    end
    @(negedge clk);
    in_valid <= 1'b0;

    wait_drained(2000);
    repeat (20) @(posedge clk);
    if (ledger.pending() != 0)
      ledger.report_mismatch($sformatf("%0d results never arrived", ledger.pending()));

    $display("sent %0d inserts and %0d removes, checked %0d results",
             ledger.inserts, ledger.removes, ledger.checked);
    $display("full-queue drops %0d, empty-queue removes %0d, peak occupancy %0d",
             ledger.full_drops, ledger.empty_removes, ledger.peak_held);
    if (ledger.errors == 0) begin
      $display("sorted_priority_queue_tb passed");
    end else begin
      $display("sorted_priority_queue_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/sorted_priority_queue_tb.sv
